// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// clocked on clk, with and without the synchronous reset rst as disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define EZVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define EZVR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ezvr_pkg.sv =====
// shared types and constants for the zyx euler rotation pipeline
// word structs, axis codes, latency and the sine table generator; no dependencies
package ezvr_pkg;

  localparam int COORD_W = 32;
  localparam int ANGLE_FIELD_W = 12;
  localparam int STAGE_LATENCY = 3;
  localparam int LATENCY = 3 * STAGE_LATENCY;
  localparam real HALF_PI = 1.5707963267948966;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic [ANGLE_FIELD_W-1:0]  angle_x;
    logic [ANGLE_FIELD_W-1:0]  angle_y;
    logic [ANGLE_FIELD_W-1:0]  angle_z;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      saturated;
  } result_t;

  // word as it travels down the pipeline
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [ANGLE_FIELD_W-1:0]  angle_x;
    logic [ANGLE_FIELD_W-1:0]  angle_y;
    logic [ANGLE_FIELD_W-1:0]  angle_z;
    logic                      sat;
  } work_t;

  // round(sin(k * quarter turn / 2^(angle_bits-2)) * 2^frac_bits), elaboration only
  function automatic int sine_entry(int k, int angle_bits, int frac_bits);
    real t;
    real x2;
    real s;
    t = real'(k) * HALF_PI * (2.0 ** (2 - angle_bits));
    x2 = t * t;
    s = 1.0 - x2 / 506.0;
    s = 1.0 - x2 / 420.0 * s;
    s = 1.0 - x2 / 342.0 * s;
    s = 1.0 - x2 / 272.0 * s;
    s = 1.0 - x2 / 210.0 * s;
    s = 1.0 - x2 / 156.0 * s;
    s = 1.0 - x2 / 110.0 * s;
    s = 1.0 - x2 / 72.0 * s;
    s = 1.0 - x2 / 42.0 * s;
    s = 1.0 - x2 / 20.0 * s;
    s = 1.0 - x2 / 6.0 * s;
    s = t * s;
    return int'(s * (2.0 ** frac_bits));
  endfunction

endpackage

// ===== design/ezvr_trig_rom.sv =====
// quarter-wave sine rom with folding: sine and cosine magnitudes plus signs
// registered read; uses ezvr_pkg for the table generator
module ezvr_trig_rom #(
  parameter int ANGLE_BITS = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic [ANGLE_BITS-1:0]   angle,
  output logic [TRIG_FRAC_BITS:0] sin_mag,
  output logic [TRIG_FRAC_BITS:0] cos_mag,
  output logic                    sin_neg,
  output logic                    cos_neg
);

  localparam int IDX_W = ANGLE_BITS - 1;
  localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
  localparam int DEPTH = QUARTER + 1;
  localparam int MAG_W = TRIG_FRAC_BITS + 1;

  typedef logic [MAG_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = MAG_W'(ezvr_pkg::sine_entry(k, ANGLE_BITS, TRIG_FRAC_BITS));
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  // odd quadrants read the table backwards
  function automatic logic [IDX_W-1:0] fold(logic [ANGLE_BITS-1:0] a);
    logic [IDX_W-1:0] r;
    r = {1'b0, a[ANGLE_BITS-3:0]};
    if (a[ANGLE_BITS-2]) begin
      return IDX_W'(QUARTER) - r;
    end
    return r;
  endfunction

  logic [ANGLE_BITS-1:0] cos_angle;
  logic [IDX_W-1:0]      sin_idx;
  logic [IDX_W-1:0]      cos_idx;

  assign cos_angle = angle + ANGLE_BITS'(QUARTER);
  assign sin_idx = fold(angle);
  assign cos_idx = fold(cos_angle);

  always_ff @(posedge clk) begin
    sin_mag <= ROM[sin_idx];
    cos_mag <= ROM[cos_idx];
    sin_neg <= angle[ANGLE_BITS-1];
    cos_neg <= cos_angle[ANGLE_BITS-1];
  end

endmodule

// ===== design/ezvr_rot_stage.sv =====
// one planar rotation: trig fetch, four products, rounded sums with clamping
// three register stages; uses ezvr_pkg and ezvr_trig_rom
module ezvr_rot_stage #(
  parameter ezvr_pkg::axis_t AXIS = ezvr_pkg::AXIS_Z,
  parameter int ANGLE_BITS = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  ezvr_pkg::work_t up_work,
  output logic            down_valid,
  output ezvr_pkg::work_t down_work
);

  localparam int COORD_W = ezvr_pkg::COORD_W;
  localparam int FIELD_W = ezvr_pkg::ANGLE_FIELD_W;
  localparam int MAG_W = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int RND_W = PROD_W - TRIG_FRAC_BITS;
  localparam int SUM_W = RND_W + 1;
  localparam logic [PROD_W-1:0] ROUND_HALF =
    {{(PROD_W-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

  // angle select, zero-extended and cut to the table's angle width
  logic [FIELD_W-1:0]            angle_field;
  logic [FIELD_W+ANGLE_BITS-1:0] angle_ext;
  logic [ANGLE_BITS-1:0]         angle;

  always_comb begin
    case (AXIS)
      ezvr_pkg::AXIS_X: angle_field = up_work.angle_x;
      ezvr_pkg::AXIS_Y: angle_field = up_work.angle_y;
      ezvr_pkg::AXIS_Z: angle_field = up_work.angle_z;
      default:          angle_field = up_work.angle_z;
    endcase
  end

  assign angle_ext = {{ANGLE_BITS{1'b0}}, angle_field};
  assign angle = angle_ext[ANGLE_BITS-1:0];

  logic [MAG_W-1:0] sin_mag;
  logic [MAG_W-1:0] cos_mag;
  logic             sin_neg;
  logic             cos_neg;

  ezvr_trig_rom #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rom (
    .clk     (clk),
    .angle   (angle),
    .sin_mag (sin_mag),
    .cos_mag (cos_mag),
    .sin_neg (sin_neg),
    .cos_neg (cos_neg)
  );

  // stage 1: trig fetch
  logic            v1;
  ezvr_pkg::work_t w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    w1 <= up_work;
  end

  // stage 2: signed trig values and products
  logic signed [TRIG_W-1:0]  sin_mag_s;
  logic signed [TRIG_W-1:0]  cos_mag_s;
  logic signed [TRIG_W-1:0]  sin_s;
  logic signed [TRIG_W-1:0]  cos_s;
  logic signed [COORD_W-1:0] a1;
  logic signed [COORD_W-1:0] b1;

  assign sin_mag_s = signed'({1'b0, sin_mag});
  assign cos_mag_s = signed'({1'b0, cos_mag});
  assign sin_s = sin_neg ? -sin_mag_s : sin_mag_s;
  assign cos_s = cos_neg ? -cos_mag_s : cos_mag_s;

  // (a, b) is the rotated plane: a' = c*a - s*b, b' = s*a + c*b
  always_comb begin
    case (AXIS)
      ezvr_pkg::AXIS_X: begin
        a1 = w1.y;
        b1 = w1.z;
      end
      ezvr_pkg::AXIS_Y: begin
        a1 = w1.z;
        b1 = w1.x;
      end
      ezvr_pkg::AXIS_Z: begin
        a1 = w1.x;
        b1 = w1.y;
      end
      default: begin
        a1 = w1.x;
        b1 = w1.y;
      end
    endcase
  end

  logic                     v2;
  ezvr_pkg::work_t          w2;
  logic signed [PROD_W-1:0] p_ca;
  logic signed [PROD_W-1:0] p_sb;
  logic signed [PROD_W-1:0] p_sa;
  logic signed [PROD_W-1:0] p_cb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    w2   <= w1;
    p_ca <= cos_s * a1;
    p_sb <= sin_s * b1;
    p_sa <= sin_s * a1;
    p_cb <= cos_s * b1;
  end

  // stage 3: round half up, sum, clamp
  function automatic logic signed [RND_W-1:0] rnd(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + signed'(ROUND_HALF);
    return signed'(t[PROD_W-1:TRIG_FRAC_BITS]);
  endfunction

  function automatic logic over(logic signed [SUM_W-1:0] v);
    return !((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1]));
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp(logic signed [SUM_W-1:0] v);
    if (over(v)) begin
      return signed'({v[SUM_W-1], {(COORD_W-1){~v[SUM_W-1]}}});
    end
    return v[COORD_W-1:0];
  endfunction

  logic signed [SUM_W-1:0]   a_sum;
  logic signed [SUM_W-1:0]   b_sum;
  logic signed [COORD_W-1:0] a_new;
  logic signed [COORD_W-1:0] b_new;
  ezvr_pkg::work_t           w3_next;

  assign a_sum = SUM_W'(rnd(p_ca)) - SUM_W'(rnd(p_sb));
  assign b_sum = SUM_W'(rnd(p_sa)) + SUM_W'(rnd(p_cb));
  assign a_new = clamp(a_sum);
  assign b_new = clamp(b_sum);

  always_comb begin
    w3_next = w2;
    w3_next.sat = w2.sat | over(a_sum) | over(b_sum);
    case (AXIS)
      ezvr_pkg::AXIS_X: begin
        w3_next.y = a_new;
        w3_next.z = b_new;
      end
      ezvr_pkg::AXIS_Y: begin
        w3_next.z = a_new;
        w3_next.x = b_new;
      end
      ezvr_pkg::AXIS_Z: begin
        w3_next.x = a_new;
        w3_next.y = b_new;
      end
      default: begin
        w3_next.x = a_new;
        w3_next.y = b_new;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else begin
      down_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    down_work <= w3_next;
  end

endmodule

// ===== design/euler_zyx_vector_rotation.sv =====
// Rotates a signed Q16.16 point about Z, then Y, then X. One word is taken
// every clock cycle (start high, busy low) and its result appears with done
// high for exactly one cycle, in the order taken. Each rotation is three
// register stages: sine/cosine rom read, the four 32x16 products, then
// rounded sums with clamping. The receiver cannot stall the block, and
// busy is high only in reset and the cycle after it. Uses ezvr_pkg and
// ezvr_rot_stage.
module euler_zyx_vector_rotation #(
  parameter int ANGLE_BITS = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ezvr_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output ezvr_pkg::result_t result
);

  logic busy_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_hold <= 1'b1;
    end else begin
      busy_hold <= 1'b0;
    end
  end

  assign busy = rst | busy_hold;

  logic            entry_valid;
  ezvr_pkg::work_t entry_work;

  assign entry_valid = start & ~busy;

  always_comb begin
    entry_work.x       = item.in_x;
    entry_work.y       = item.in_y;
    entry_work.z       = item.in_z;
    entry_work.angle_x = item.angle_x;
    entry_work.angle_y = item.angle_y;
    entry_work.angle_z = item.angle_z;
    entry_work.sat     = 1'b0;
  end

  logic            z_valid;
  logic            y_valid;
  ezvr_pkg::work_t z_work;
  ezvr_pkg::work_t y_work;
  ezvr_pkg::work_t x_work;

  ezvr_rot_stage #(
    .AXIS           (ezvr_pkg::AXIS_Z),
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_z (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (entry_valid),
    .up_work    (entry_work),
    .down_valid (z_valid),
    .down_work  (z_work)
  );

  ezvr_rot_stage #(
    .AXIS           (ezvr_pkg::AXIS_Y),
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_y (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (z_valid),
    .up_work    (z_work),
    .down_valid (y_valid),
    .down_work  (y_work)
  );

  ezvr_rot_stage #(
    .AXIS           (ezvr_pkg::AXIS_X),
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_x (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (y_valid),
    .up_work    (y_work),
    .down_valid (done),
    .down_work  (x_work)
  );

  always_comb begin
    result.out_x     = x_work.x;
    result.out_y     = x_work.y;
    result.out_z     = x_work.z;
    result.saturated = x_work.sat;
  end

endmodule

// ===== design/ezvr_checker.sv =====
// port-level checks for euler_zyx_vector_rotation, attached by bind
// uses assert_macros.svh and ezvr_pkg
`include "assert_macros.svh"

module ezvr_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input ezvr_pkg::item_t   item,
  input logic              busy,
  input logic              done,
  input ezvr_pkg::result_t result
);

  localparam int LAT = ezvr_pkg::LATENCY;

  logic zero_angles;

  assign zero_angles = (item.angle_x == '0) && (item.angle_y == '0) && (item.angle_z == '0);

  `EZVR_ASSERT_RST(a_busy_in_reset, rst |-> busy, "busy low during reset")

  `EZVR_ASSERT_RST(a_quiet_after_reset, rst |=> !done, "done raised right after reset")

  // every accepted word comes out after the fixed latency
  `EZVR_ASSERT(a_latency, (start && !busy) |-> ##LAT done, "word lost in pipeline")

  // zero angles leave the point untouched and never clamp
  `EZVR_ASSERT(a_zero_angle_identity,
    (start && !busy && zero_angles) |-> ##LAT (result.out_x == $past(item.in_x, LAT)
      && result.out_y == $past(item.in_y, LAT) && result.out_z == $past(item.in_z, LAT)
      && !result.saturated),
    "zero rotation changed the point")

endmodule

bind euler_zyx_vector_rotation ezvr_checker u_checker (.*);
